// ===== design/gipd_pkg.sv =====
// Package for the grid increasing-path block: sizes, the line buffer entry
// type and the saturating length increment. No dependencies.
`timescale 1ns / 1ps

package gipd_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned ColBits    = $clog2(MaxWidth);
  localparam int unsigned WidthBits  = 11;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned LengthBits = 16;

  localparam logic [LengthBits-1:0] LenMax = {LengthBits{1'b1}};
  localparam logic [LengthBits-1:0] LenOne = LengthBits'(1);

  typedef logic [ColBits-1:0]          col_t;
  typedef logic [LengthBits-1:0]       len_t;
  typedef logic signed [ValueBits-1:0] value_t;

  // One line buffer entry: the value and path length of a cell one row up.
  typedef struct packed {
    value_t value;
    len_t   length;
  } entry_t;

  function automatic len_t sat_inc(input len_t len);
    return (len == LenMax) ? LenMax : len + LenOne;
  endfunction

endpackage

// ===== design/grid_increasing_path_dp.sv =====
// Top level of the grid increasing-path block: position tracking, line
// buffer access with forwarding, and the output register.
// Depends on gipd_pkg, gipd_linebuf and gipd_cell.
`timescale 1ns / 1ps

// Cells of a grid arrive in raster order as words on the input channel
// (in_valid_i / in_ready_o), each with a signed value and a flag for the
// grid's last cell. For every word the block returns one word on the output
// channel (out_valid_o / out_ready_i): the longest increasing right/down
// path ending at that cell, the running maximum over the grid so far, and
// the last-cell flag. Lengths saturate at 65535.
// The user sets the row width through cfg_we_i / cfg_wdata_i only while the
// block is idle (not enforced); zero acts as one and values above 1024 as 1024.
// The line buffer read is issued at the edge that accepts the word and
// loads it into the read stage; when the word leaves the read stage, the
// cell is computed and loaded into the output register. The block takes
// one word per cycle while the receiver does not stall. The left
// neighbour is the previous cell's freshly computed result, and the upper
// neighbour comes from the line buffer, which is read at acceptance and
// written as the result is registered; a read of the entry written at that
// same edge (one-cell rows) is served from a forwarding register.
// When the receiver stalls, the output register holds its word, the word
// behind it waits in the read stage, and in_ready_o drops until the output
// moves. Reset clears the position, the running maximum and the row width
// (to one); the line buffer needs no clearing because each row is written
// before it is read.

module grid_increasing_path_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gipd_pkg::WidthBits-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [gipd_pkg::ValueBits-1:0] cell_value_i,
  input  logic                                last_cell_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gipd_pkg::LengthBits-1:0]     path_length_o,
  output logic [gipd_pkg::LengthBits-1:0]     longest_so_far_o,
  output logic                                grid_done_o
);

  localparam logic [gipd_pkg::WidthBits-1:0] WidthMax =
    gipd_pkg::WidthBits'(gipd_pkg::MaxWidth);
  localparam logic [gipd_pkg::WidthBits-1:0] WidthOne = gipd_pkg::WidthBits'(1);

  // Configuration and position state.
  logic [gipd_pkg::WidthBits-1:0] row_width_q;
  logic [gipd_pkg::WidthBits-1:0] eff_width;
  gipd_pkg::col_t                 col_q, col_d;
  logic                           first_row_q, first_row_d;
  logic [gipd_pkg::WidthBits-1:0] col_next;

  // Read stage: the accepted word waiting for its line buffer data.
  logic             s1_valid_q;
  gipd_pkg::value_t s1_value_q;
  logic             s1_last_q;
  logic             s1_row_end_q;
  logic             s1_first_row_q;
  gipd_pkg::col_t   s1_col_q;

  // Forwarding of the entry written at the same edge as the read.
  logic             fwd_valid_q;
  gipd_pkg::entry_t fwd_data_q;

  // Left neighbour and running maximum.
  gipd_pkg::value_t left_value_q, left_value_d;
  gipd_pkg::len_t   left_length_q, left_length_d;
  gipd_pkg::len_t   best_q, best_d;

  // Output register.
  logic           out_valid_q;
  gipd_pkg::len_t out_len_q;
  gipd_pkg::len_t out_best_q;
  logic           out_done_q;

  logic             accept;
  logic             advance;
  gipd_pkg::entry_t rd_entry;
  gipd_pkg::entry_t above;
  gipd_pkg::entry_t wr_entry;
  gipd_pkg::len_t   cell_len;
  gipd_pkg::len_t   cell_best;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (row_width_q == '0) begin
      eff_width = WidthOne;
    end else if (row_width_q > WidthMax) begin
      eff_width = WidthMax;
    end else begin
      eff_width = row_width_q;
    end
  end

  assign col_next = {1'b0, col_q} + WidthOne;

  // Position update for the word being accepted.
  always_comb begin
    col_d       = col_q;
    first_row_d = first_row_q;
    if (accept) begin
      if (last_cell_i) begin
        col_d       = '0;
        first_row_d = 1'b1;
      end else if (col_next >= eff_width) begin
        col_d       = '0;
        first_row_d = 1'b0;
      end else begin
        col_d = col_next[gipd_pkg::ColBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WidthOne;
      col_q       <= '0;
      first_row_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      col_q       <= col_d;
      first_row_q <= first_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= advance && (s1_col_q == col_q);
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_value_q     <= cell_value_i;
      s1_last_q      <= last_cell_i;
      s1_row_end_q   <= (col_next >= eff_width);
      s1_first_row_q <= first_row_q;
      s1_col_q       <= col_q;
      fwd_data_q     <= wr_entry;
    end
  end

  gipd_linebuf u_linebuf (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (s1_col_q),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_entry)
  );

  assign above = fwd_valid_q ? fwd_data_q : rd_entry;

  gipd_cell u_cell (
    .value_i       (s1_value_q),
    .has_left_i    (s1_col_q != '0),
    .has_above_i   (!s1_first_row_q),
    .left_value_i  (left_value_q),
    .left_length_i (left_length_q),
    .above_i       (above),
    .best_i        (best_q),
    .length_o      (cell_len),
    .best_o        (cell_best)
  );

  assign wr_entry.value  = s1_value_q;
  assign wr_entry.length = cell_len;

  // Left neighbour and running maximum follow the word leaving the read stage.
  always_comb begin
    left_value_d  = left_value_q;
    left_length_d = left_length_q;
    best_d        = best_q;
    if (advance) begin
      if (s1_last_q || s1_row_end_q) begin
        left_value_d  = '0;
        left_length_d = '0;
      end else begin
        left_value_d  = s1_value_q;
        left_length_d = cell_len;
      end
      best_d = s1_last_q ? '0 : cell_best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_value_q  <= '0;
      left_length_q <= '0;
      best_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      left_value_q  <= left_value_d;
      left_length_q <= left_length_d;
      best_q        <= best_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_len_q  <= cell_len;
      out_best_q <= cell_best;
      out_done_q <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign path_length_o    = out_len_q;
  assign longest_so_far_o = out_best_q;
  assign grid_done_o      = out_done_q;

endmodule

// ===== design/gipd_linebuf.sv =====
// Previous-row line buffer: one write port and one read port with a
// registered read. Depends on gipd_pkg.
`timescale 1ns / 1ps

module gipd_linebuf (
  input  logic             clk_i,
  input  logic             we_i,
  input  gipd_pkg::col_t   waddr_i,
  input  gipd_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  gipd_pkg::col_t   raddr_i,
  output gipd_pkg::entry_t rdata_o
);

  gipd_pkg::entry_t mem [gipd_pkg::MaxWidth];
  gipd_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read before write: a read of the entry written at the same edge returns
  // the old contents, so the caller forwards around that case.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/gipd_cell.sv =====
// Path length of one cell from its left and upper neighbours, and the new
// running maximum. Purely combinational. Depends on gipd_pkg.
`timescale 1ns / 1ps

module gipd_cell (
  input  gipd_pkg::value_t value_i,
  input  logic             has_left_i,
  input  logic             has_above_i,
  input  gipd_pkg::value_t left_value_i,
  input  gipd_pkg::len_t   left_length_i,
  input  gipd_pkg::entry_t above_i,
  input  gipd_pkg::len_t   best_i,
  output gipd_pkg::len_t   length_o,
  output gipd_pkg::len_t   best_o
);

  gipd_pkg::len_t left_cand;
  gipd_pkg::len_t up_cand;

  always_comb begin
    left_cand = gipd_pkg::LenOne;
    up_cand   = gipd_pkg::LenOne;
    if (has_left_i && (left_value_i < value_i)) begin
      left_cand = gipd_pkg::sat_inc(left_length_i);
    end
    if (has_above_i && (above_i.value < value_i)) begin
      up_cand = gipd_pkg::sat_inc(above_i.length);
    end
  end

  assign length_o = (left_cand > up_cand) ? left_cand : up_cand;
  assign best_o   = (length_o > best_i) ? length_o : best_i;

endmodule
